// ===== rtl/core/somsort_pkg.sv =====
package somsort_pkg;

    localparam int MAX_SIDE    = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(MAX_SIDE);
    localparam int SIDE_W      = 4;
    localparam int SIDE_RESET  = 8;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    typedef enum logic [4:0] {
        ST_LOAD     = 5'b00001,
        ST_SETTLE   = 5'b00010,
        ST_EVEN     = 5'b00100,
        ST_ODD_FILL = 5'b01000,
        ST_ODD_EMIT = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/somsort_cell.sv =====
module somsort_cell
    import somsort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     in_val,
    input  logic       in_vld,
    input  value_t     shift_val,
    input  logic       shift_full,
    output value_t     pass_val,
    output logic       pass_vld,
    output value_t     held_val,
    output logic       held_full
);

    value_t held_reg;
    logic   full_reg;
    value_t pass_reg;
    logic   pass_vld_reg;
    logic   less;

    assign less = in_val < held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            full_reg     <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            full_reg     <= shift_full;
            pass_vld_reg <= 1'b0;
        end
        else if (in_vld)
        begin
            full_reg     <= 1'b1;
            pass_vld_reg <= full_reg;
        end
        else
        begin
            pass_vld_reg <= 1'b0;
        end
    end

    // The smaller word stays here, the larger one moves on to the right.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            held_reg <= shift_val;
        end
        else if (in_vld)
        begin
            if (!full_reg)
            begin
                held_reg <= in_val;
            end
            else if (less)
            begin
                held_reg <= in_val;
                pass_reg <= held_reg;
            end
            else
            begin
                pass_reg <= in_val;
            end
        end
    end

    assign pass_val  = pass_reg;
    assign pass_vld  = pass_vld_reg;
    assign held_val  = held_reg;
    assign held_full = full_reg;

endmodule

// ===== rtl/core/somsort_chain.sv =====
module somsort_chain
    import somsort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     in_val,
    input  logic       in_vld,
    output value_t     head_val
);

    value_t pass_val  [DEPTH];
    logic   pass_vld  [DEPTH];
    value_t held_val  [DEPTH];
    logic   held_full [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            value_t cin_val;
            logic   cin_vld;
            value_t sh_val;
            logic   sh_full;

            if (i == 0)
            begin : g_first
                assign cin_val = in_val;
                assign cin_vld = in_vld;
            end
            else
            begin : g_mid
                assign cin_val = pass_val[i-1];
                assign cin_vld = pass_vld[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign sh_val  = '0;
                assign sh_full = 1'b0;
            end
            else
            begin : g_link
                assign sh_val  = held_val[i+1];
                assign sh_full = held_full[i+1];
            end

            somsort_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .in_val     (cin_val),
                .in_vld     (cin_vld),
                .shift_val  (sh_val),
                .shift_full (sh_full),
                .pass_val   (pass_val[i]),
                .pass_vld   (pass_vld[i]),
                .held_val   (held_val[i]),
                .held_full  (held_full[i])
            );
        end
    endgenerate

    assign head_val = held_val[0];

endmodule

// ===== rtl/core/somsort_row_stack.sv =====
module somsort_row_stack
    import somsort_pkg::*;
(
    input  logic        clk,
    input  stack_ctrl_t ctrl,
    input  value_t      push_val,
    output value_t      top_val
);

    value_t buf_reg [MAX_SIDE];

    // Last in, first out: an odd row comes back reversed.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            buf_reg[0] <= push_val;
            for (int k = 1; k < MAX_SIDE; k++)
            begin
                buf_reg[k] <= buf_reg[k-1];
            end
        end
        else if (ctrl.pop)
        begin
            for (int k = 0; k < MAX_SIDE - 1; k++)
            begin
                buf_reg[k] <= buf_reg[k+1];
            end
        end
    end

    assign top_val = buf_reg[0];

endmodule

// ===== rtl/core/snake_order_matrix_sort_core.sv =====
// Sorts one n x n data set (n = side, with 0 taken as 1 and values above 8 as 8) and
// returns it in snake order: even rows ascend left to right, odd rows descend.
// Words are taken one per cycle while busy is low, through a 64-cell insertion chain.
// After the last word of a set busy rises: the chain settles, then drains one
// word per cycle from its head, pausing while an odd row is popped. Even rows go
// straight out, one result per cycle; an odd row is first drained into a row
// stack and then popped out. Each result is shown for exactly one cycle with
// result_strobe high and cannot be held off; the one marked last arrives in the
// same cycle that busy falls. Write side only while busy is low; a write drops any
// partly loaded set.
module snake_order_matrix_sort_core
    import somsort_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  value_t            value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIDE_W-1:0] cfg_data,
    output logic              result_strobe,
    output value_t            value_res,
    output logic [IDX_W-1:0]  row,
    output logic [IDX_W-1:0]  column,
    output logic              last
);

    state_t              state_reg, state_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [CNT_W-1:0]    load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]    settle_cnt_reg, settle_cnt_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    col_reg, col_next;
    logic                strobe_reg, strobe_next;
    value_t              value_res_reg, value_res_next;
    logic [IDX_W-1:0]    row_out_reg;
    logic [IDX_W-1:0]    col_out_reg;
    logic                last_reg, last_next;

    logic [SIDE_W-1:0]   n_side;
    logic [2*SIDE_W-1:0] n_sq;
    logic [CNT_W-1:0]    total_m1;
    logic [IDX_W-1:0]    n_m1;
    logic                accept;
    logic                cfg_write;
    logic                row_end;
    logic                mat_end;
    cell_ctrl_t          chain_ctrl;
    stack_ctrl_t         stack_ctrl;
    value_t              head_val;
    value_t              stack_top;

    always_comb
    begin
        if (side_reg == '0)
        begin
            n_side = SIDE_W'(1);
        end
        else if (side_reg > SIDE_W'(MAX_SIDE))
        begin
            n_side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            n_side = side_reg;
        end
    end

    assign n_sq     = (2*SIDE_W)'(n_side) * (2*SIDE_W)'(n_side);
    assign total_m1 = CNT_W'(n_sq - (2*SIDE_W)'(1));
    assign n_m1     = IDX_W'(n_side - SIDE_W'(1));

    assign busy      = (state_reg != ST_LOAD);
    assign accept    = start && !busy;
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;
    assign row_end   = (col_reg == n_m1);
    assign mat_end   = row_end && (row_reg == n_m1);

    assign chain_ctrl.shift = (state_reg == ST_EVEN) || (state_reg == ST_ODD_FILL);
    assign chain_ctrl.clear = cfg_write;
    assign stack_ctrl.push  = (state_reg == ST_ODD_FILL);
    assign stack_ctrl.pop   = (state_reg == ST_ODD_EMIT);

    always_comb
    begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        settle_cnt_next = settle_cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        strobe_next     = 1'b0;
        value_res_next  = value_res_reg;
        last_next       = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (cfg_write)
                begin
                    load_cnt_next = '0;
                end
                else if (accept)
                begin
                    if (load_cnt_reg == total_m1)
                    begin
                        load_cnt_next   = '0;
                        settle_cnt_next = '0;
                        state_next      = ST_SETTLE;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_SETTLE:
            begin
                // The last word may still be walking down the chain.
                if (settle_cnt_reg == total_m1)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_EVEN;
                end
                else
                begin
                    settle_cnt_next = settle_cnt_reg + CNT_W'(1);
                end
            end
            ST_EVEN:
            begin
                strobe_next    = 1'b1;
                value_res_next = head_val;
                last_next      = mat_end;
                if (row_end)
                begin
                    col_next = '0;
                    if (mat_end)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        row_next   = row_reg + IDX_W'(1);
                        state_next = ST_ODD_FILL;
                    end
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            ST_ODD_FILL:
            begin
                if (row_end)
                begin
                    col_next   = '0;
                    state_next = ST_ODD_EMIT;
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            ST_ODD_EMIT:
            begin
                strobe_next    = 1'b1;
                value_res_next = stack_top;
                last_next      = mat_end;
                if (row_end)
                begin
                    col_next = '0;
                    if (mat_end)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        row_next   = row_reg + IDX_W'(1);
                        state_next = ST_EVEN;
                    end
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            side_reg       <= SIDE_W'(SIDE_RESET);
            load_cnt_reg   <= '0;
            settle_cnt_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            settle_cnt_reg <= settle_cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            strobe_reg     <= strobe_next;
            last_reg       <= last_next;
            if (cfg_write)
            begin
                side_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_res_reg <= value_res_next;
        row_out_reg   <= row_reg;
        col_out_reg   <= col_reg;
    end

    somsort_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chain_ctrl),
        .in_val   (value),
        .in_vld   (accept),
        .head_val (head_val)
    );

    somsort_row_stack u_stack (
        .clk      (clk),
        .ctrl     (stack_ctrl),
        .push_val (head_val),
        .top_val  (stack_top)
    );

    assign result_strobe = strobe_reg;
    assign value_res     = value_res_reg;
    assign row           = row_out_reg;
    assign column        = col_out_reg;
    assign last          = last_reg;

endmodule

// ===== rtl/core/somsort_checker.sv =====
module somsort_checker
    import somsort_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              cfg_ready,
    input logic              result_strobe,
    input logic              last
);

    // Only the final word of a matrix may appear once the block is idle again.
    a_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("non-final result while idle");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !result_strobe)
        else $error("result right after the final word");

    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("configuration offered while busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_strobe)
        else $error("result one cycle after an idle cycle");

endmodule

bind snake_order_matrix_sort_core somsort_checker u_somsort_checker (.*);
